/* sv/assert_macros.svh */
// Assertion macros for the RTL.
// No dependencies; each file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while arst_n is low.
`define ASSERT_AR(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/gnpt_pkg.sv */
// Package for the greedy nearest-point path tracer: widths, codes, defaults.
// No dependencies.
package gnpt_pkg;

	localparam int CoordW   = 10;
	localparam int PixW     = 8;
	localparam int ImgW     = 11;
	localparam int GapW     = 10;
	localparam int LenW     = 13;
	localparam int CfgDataW = 13;
	localparam int CfgAddrW = 2;

	localparam int DefaultMaxPoints = 4096;
	localparam int DefaultMaxWidth  = 1024;

	localparam logic [PixW-1:0]   BrightLevel   = 8'd128;
	localparam int                NearStop      = 4;
	localparam logic [LenW-1:0]   LenMax        = 13'd8191;
	localparam logic [ImgW-1:0]   ImgWidthReset = 11'd640;
	localparam logic [GapW-1:0]   MinGapReset   = 10'd4;
	localparam logic [LenW-1:0]   MinLenReset   = 13'd0;

	localparam logic ModeLoad  = 1'b0;
	localparam logic ModeFetch = 1'b1;

	typedef enum logic [CfgAddrW-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_MIN_GAP_SQ   = 2'd1,
		REG_MIN_PATH_LEN = 2'd2
	} cfg_reg_t;

endpackage

/* sv/greedy_nearest_point_path_tracer.sv */
// Greedy nearest-point path tracer: point store, scan sequencer, output register.
// Depends on gnpt_pkg and assert_macros.svh.
//
// Usage:
// s_axis carries requests: tdata = pixel, tuser = {frame_start, mode}.
// A load request (mode 0) takes one raster pixel; pixels
// above 128 store their (column, row). frame_start clears the store first.
// A fetch request (mode 1) returns one vertex on m_axis: tdata = {y, x},
// tuser = {overflow, done_res, drop_path, new_path}.
// A fetch scans the stored points and presents its vertex once the scan
// ends: one shared distance unit (two 10-bit squares, then add and compare)
// walks the point memory one entry per cycle, stopping early on a distance
// below 4. The first fetch after loading passes through ST_PRIME and ST_CURS
// to read the last stored point.
// s_axis_tready is high only while no fetch is in progress. The result sits
// in an output register; loads are still taken while it waits, and a
// further fetch finishes its scan then holds until m_axis frees the register.
// Reset clears counters and flags and loads the default configuration; the point memory needs no
// clearing pass since only entries below the count are read.
`include "assert_macros.svh"

module greedy_nearest_point_path_tracer #(
	parameter int MAX_POINTS = gnpt_pkg::DefaultMaxPoints,
	parameter int MAX_WIDTH  = gnpt_pkg::DefaultMaxWidth
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // [7:0] pixel
	input  logic [1:0]                    s_axis_tuser,  // [0] mode, [1] frame_start
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [23:0]                   m_axis_tdata,  // [9:0] vertex_x, [19:10] vertex_y
	output logic [3:0]                    m_axis_tuser,  // new_path, drop_path, done_res, overflow
	input  logic                          cfg_we,
	input  logic [gnpt_pkg::CfgAddrW-1:0] cfg_addr,
	input  logic [gnpt_pkg::CfgDataW-1:0] cfg_wdata
);

	localparam int CW    = gnpt_pkg::CoordW;
	localparam int IdxW  = $clog2(MAX_POINTS);
	localparam int CntW  = $clog2(MAX_POINTS + 1);
	localparam int ColW  = $clog2(MAX_WIDTH);
	localparam int WW    = (ColW + 1 > gnpt_pkg::ImgW) ? ColW + 1 : gnpt_pkg::ImgW;
	localparam int DistW = 2 * CW + 1;
	localparam int WordW = 2 * CW + 1;
	localparam int SqW   = 2 * CW;
	localparam int LenW  = gnpt_pkg::LenW;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRIME,
		ST_CURS,
		ST_SCAN,
		ST_DECIDE
	} state_t;

	state_t state_q;

	logic [gnpt_pkg::ImgW-1:0] img_w_q;
	logic [gnpt_pkg::GapW-1:0] gap_q;
	logic [LenW-1:0]           minlen_q;

	logic [CntW-1:0] cnt_q;
	logic [ColW-1:0] col_q;
	logic [CW-1:0]   row_q;
	logic [CW-1:0]   cur_x_q, cur_y_q;
	logic [LenW-1:0] plen_q;
	logic            emitted_q;
	logic            ovf_q;

	logic [CntW-1:0]  scan_i_q;
	logic             found_q;
	logic [IdxW-1:0]  best_idx_q;
	logic [DistW-1:0] best_d_q;
	logic [CW-1:0]    best_x_q, best_y_q;

	logic            v_s1;
	logic [IdxW-1:0] idx_s1;
	logic            v_s2;
	logic [IdxW-1:0] idx_s2;
	logic [CW-1:0]   px_s2, py_s2;
	logic [SqW-1:0]  sqx_s2, sqy_s2;

	logic            m_valid_q;
	logic [CW-1:0]   o_x_q, o_y_q;
	logic            o_new_q, o_drop_q, o_done_q, o_ovf_q;

	logic [WordW-1:0] mem [MAX_POINTS];
	logic [WordW-1:0] rd_data_q;
	logic             mem_we;
	logic [IdxW-1:0]  mem_wa;
	logic [WordW-1:0] mem_wd;
	logic [IdxW-1:0]  mem_ra;

	logic            in_acc;
	logic            in_mode, in_fs;
	logic [7:0]      in_pix;
	logic            slot_free;

	// load path
	logic [WW-1:0]   w_ext, w_eff, col_next;
	logic [CntW-1:0] cnt_base;
	logic [ColW-1:0] col_base;
	logic [CW-1:0]   row_base;
	logic            bright, store_ok;

	// scan path
	logic            rd_live;
	logic [CW-1:0]   rd_x, rd_y, dx, dy;
	logic [DistW-1:0] d_s2;
	logic            take, stop, issue, scan_end;

	// decide path
	logic            dec_new, dec_drop;
	logic [LenW-1:0] dec_len0, dec_len;

	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign in_mode   = s_axis_tuser[0];
	assign in_fs     = s_axis_tuser[1];
	assign in_pix    = s_axis_tdata[7:0];
	assign slot_free = !m_valid_q || m_axis_tready;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {4'b0, o_y_q, o_x_q};
	assign m_axis_tuser  = {o_ovf_q, o_done_q, o_drop_q, o_new_q};

	always_comb begin
		w_ext = WW'(img_w_q);
		if (w_ext == '0) begin
			w_eff = WW'(1);
		end else if (w_ext > WW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
		cnt_base = in_fs ? '0 : cnt_q;
		col_base = in_fs ? '0 : col_q;
		row_base = in_fs ? '0 : row_q;
		col_next = WW'(col_base) + WW'(1);
		bright   = in_pix > gnpt_pkg::BrightLevel;
		store_ok = cnt_base < CntW'(MAX_POINTS);
	end

	assign {rd_live, rd_x, rd_y} = rd_data_q;
	assign dx = (cur_x_q > rd_x) ? cur_x_q - rd_x : rd_x - cur_x_q;
	assign dy = (cur_y_q > rd_y) ? cur_y_q - rd_y : rd_y - cur_y_q;

	assign d_s2     = DistW'(sqx_s2) + DistW'(sqy_s2);
	assign take     = v_s2 && (!found_q || d_s2 < best_d_q);
	assign stop     = take && (d_s2 < DistW'(gnpt_pkg::NearStop));
	assign issue    = (state_q == ST_SCAN) && (scan_i_q < cnt_q);
	assign scan_end = stop || (!issue && !v_s1 && !v_s2 && state_q == ST_SCAN);

	always_comb begin
		dec_new  = 1'b0;
		dec_drop = 1'b0;
		dec_len0 = plen_q;
		if (!emitted_q) begin
			dec_new  = 1'b1;
			dec_len0 = '0;
		end else if (best_d_q >= DistW'(gap_q)) begin
			if (plen_q < minlen_q) begin
				dec_drop = 1'b1;
			end else begin
				dec_new = 1'b1;
			end
			dec_len0 = '0;
		end
		dec_len = (dec_len0 < gnpt_pkg::LenMax) ? dec_len0 + LenW'(1) : dec_len0;
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = best_idx_q;
		mem_wd = {1'b0, best_x_q, best_y_q};
		mem_ra = scan_i_q[IdxW-1:0];
		if (state_q == ST_PRIME) begin
			mem_ra = IdxW'(cnt_q - CntW'(1));
		end
		if (in_acc && in_mode == gnpt_pkg::ModeLoad && bright && store_ok) begin
			mem_we = 1'b1;
			mem_wa = cnt_base[IdxW-1:0];
			mem_wd = {1'b1, CW'(col_base), row_base};
		end else if (state_q == ST_DECIDE && slot_free && found_q) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			img_w_q    <= gnpt_pkg::ImgWidthReset;
			gap_q      <= gnpt_pkg::MinGapReset;
			minlen_q   <= gnpt_pkg::MinLenReset;
			cnt_q      <= '0;
			col_q      <= '0;
			row_q      <= '0;
			cur_x_q    <= '0;
			cur_y_q    <= '0;
			plen_q     <= '0;
			emitted_q  <= 1'b0;
			ovf_q      <= 1'b0;
			scan_i_q   <= '0;
			found_q    <= 1'b0;
			best_idx_q <= '0;
			best_d_q   <= '0;
			best_x_q   <= '0;
			best_y_q   <= '0;
			v_s1       <= 1'b0;
			idx_s1     <= '0;
			v_s2       <= 1'b0;
			idx_s2     <= '0;
			px_s2      <= '0;
			py_s2      <= '0;
			sqx_s2     <= '0;
			sqy_s2     <= '0;
			m_valid_q  <= 1'b0;
			o_x_q      <= '0;
			o_y_q      <= '0;
			o_new_q    <= 1'b0;
			o_drop_q   <= 1'b0;
			o_done_q   <= 1'b0;
			o_ovf_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					gnpt_pkg::REG_IMAGE_WIDTH:  img_w_q  <= cfg_wdata[gnpt_pkg::ImgW-1:0];
					gnpt_pkg::REG_MIN_GAP_SQ:   gap_q    <= cfg_wdata[gnpt_pkg::GapW-1:0];
					gnpt_pkg::REG_MIN_PATH_LEN: minlen_q <= cfg_wdata[LenW-1:0];
					default: ;
				endcase
			end

			if (m_valid_q && m_axis_tready && state_q != ST_DECIDE) begin
				m_valid_q <= 1'b0;
			end

			// distance pipeline; an early stop flushes it
			v_s1   <= issue && !stop;
			idx_s1 <= scan_i_q[IdxW-1:0];
			v_s2   <= v_s1 && rd_live && !stop;
			idx_s2 <= idx_s1;
			px_s2  <= rd_x;
			py_s2  <= rd_y;
			sqx_s2 <= dx * dx;
			sqy_s2 <= dy * dy;
			if (issue) begin
				scan_i_q <= scan_i_q + CntW'(1);
			end
			if (take) begin
				found_q    <= 1'b1;
				best_idx_q <= idx_s2;
				best_d_q   <= d_s2;
				best_x_q   <= px_s2;
				best_y_q   <= py_s2;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (in_mode == gnpt_pkg::ModeLoad) begin
							if (in_fs) begin
								cur_x_q   <= '0;
								cur_y_q   <= '0;
								plen_q    <= '0;
								emitted_q <= 1'b0;
								ovf_q     <= 1'b0;
							end
							if (bright) begin
								if (store_ok) begin
									cnt_q <= cnt_base + CntW'(1);
								end else begin
									cnt_q <= cnt_base;
									ovf_q <= 1'b1;
								end
							end else begin
								cnt_q <= cnt_base;
							end
							if (col_next >= w_eff) begin
								col_q <= '0;
								row_q <= row_base + CW'(1);
							end else begin
								col_q <= ColW'(col_next);
								row_q <= row_base;
							end
						end else begin
							scan_i_q <= '0;
							found_q  <= 1'b0;
							if (!emitted_q && cnt_q != '0) begin
								state_q <= ST_PRIME;
							end else begin
								state_q <= ST_SCAN;
							end
						end
					end
				end
				ST_PRIME: begin
					state_q <= ST_CURS;
				end
				ST_CURS: begin
					cur_x_q <= rd_x;
					cur_y_q <= rd_y;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_end) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (slot_free) begin
						m_valid_q <= 1'b1;
						o_ovf_q   <= ovf_q;
						if (found_q) begin
							o_x_q     <= best_x_q;
							o_y_q     <= best_y_q;
							o_new_q   <= dec_new;
							o_drop_q  <= dec_drop;
							o_done_q  <= 1'b0;
							cur_x_q   <= best_x_q;
							cur_y_q   <= best_y_q;
							plen_q    <= dec_len;
							emitted_q <= 1'b1;
						end else begin
							o_x_q    <= '0;
							o_y_q    <= '0;
							o_new_q  <= 1'b0;
							o_drop_q <= 1'b0;
							o_done_q <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_AR(a_cnt_bound, cnt_q <= CntW'(MAX_POINTS), "point count beyond store depth")
	`ASSERT_AR(a_pipe_in_scan, (v_s1 || v_s2) |-> (state_q == ST_SCAN), "distance pipe busy outside scan")
	`ASSERT_AR(a_best_in_range, (found_q && (state_q == ST_SCAN || state_q == ST_DECIDE)) |-> (CntW'(best_idx_q) < cnt_q), "best index beyond count")
	`ASSERT_AR(a_out_from_decide, $rose(m_valid_q) |-> $past(state_q == ST_DECIDE), "result without decide")
	`ASSERT_AR(a_fetch_busy, (in_acc && in_mode == gnpt_pkg::ModeFetch) |=> !s_axis_tready, "fetch did not block input")

endmodule

/* dv/testbench.sv */
// Self-checking testbench for greedy_nearest_point_path_tracer: drives load and fetch
// requests, predicts every vertex in a scoreboard class and checks results in order.
// Depends on gnpt_pkg and the RTL of the tracer; nothing else.
module testbench;

	localparam int CycleLimit   = 1_000_000;
	localparam int SettleCycles = 24;

	typedef struct packed {
		logic [gnpt_pkg::CoordW-1:0] x;
		logic [gnpt_pkg::CoordW-1:0] y;
		logic                        new_path;
		logic                        drop_path;
		logic                        done;
		logic                        ovf;
	} vertex_t;

	class vertex_scoreboard;
		logic [gnpt_pkg::ImgW-1:0]   img_width;
		logic [gnpt_pkg::GapW-1:0]   gap_sq;
		logic [gnpt_pkg::LenW-1:0]   min_len;
		logic [gnpt_pkg::CoordW-1:0] pt_x [gnpt_pkg::DefaultMaxPoints];
		logic [gnpt_pkg::CoordW-1:0] pt_y [gnpt_pkg::DefaultMaxPoints];
		bit                          pt_live [gnpt_pkg::DefaultMaxPoints];
		int unsigned                 n_points, col, row, path_len;
		logic [gnpt_pkg::CoordW-1:0] cur_x, cur_y;
		bit                          emitted, lost;
		vertex_t                     expected_q[$];
		int                          errors, n_loads, n_fetches, n_checked;
		int                          n_starts, n_drops, n_empty, n_lost;

		function new();
			img_width = gnpt_pkg::ImgWidthReset;
			gap_sq    = gnpt_pkg::MinGapReset;
			min_len   = gnpt_pkg::MinLenReset;
			clear_frame();
			errors = 0; n_loads = 0; n_fetches = 0; n_checked = 0;
			n_starts = 0; n_drops = 0; n_empty = 0; n_lost = 0;
		endfunction

		function void clear_frame();
			foreach (pt_live[i]) pt_live[i] = 0;
			n_points = 0; col = 0; row = 0; path_len = 0;
			cur_x = '0; cur_y = '0; emitted = 0; lost = 0;
		endfunction

		function void set_reg(gnpt_pkg::cfg_reg_t r, logic [gnpt_pkg::CfgDataW-1:0] v);
			case (r)
				gnpt_pkg::REG_IMAGE_WIDTH:  img_width = v[gnpt_pkg::ImgW-1:0];
				gnpt_pkg::REG_MIN_GAP_SQ:   gap_sq    = v[gnpt_pkg::GapW-1:0];
				gnpt_pkg::REG_MIN_PATH_LEN: min_len   = v[gnpt_pkg::LenW-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned live_count();
			int unsigned n;
			n = 0;
			foreach (pt_live[i]) n += pt_live[i];
			return n;
		endfunction

		function void note_request(logic mode, logic [gnpt_pkg::PixW-1:0] pixel, logic fs);
			int unsigned w, i, d, dx, dy, best, best_d;
			bit found;
			vertex_t v;
			if (mode == gnpt_pkg::ModeLoad) begin
				n_loads++;
				if (fs) clear_frame();
				w = img_width;
				if (w == 0) w = 1;
				if (w > gnpt_pkg::DefaultMaxWidth) w = gnpt_pkg::DefaultMaxWidth;
				if (pixel > gnpt_pkg::BrightLevel) begin
					if (n_points < gnpt_pkg::DefaultMaxPoints) begin
						pt_x[n_points]    = gnpt_pkg::CoordW'(col);
						pt_y[n_points]    = gnpt_pkg::CoordW'(row);
						pt_live[n_points] = 1;
						n_points++;
					end else begin
						lost = 1;
					end
				end
				if (col + 1 >= w) begin
					col = 0;
					row = (row + 1) % gnpt_pkg::DefaultMaxWidth;
				end else begin
					col++;
				end
				return;
			end
			n_fetches++;
			v = '0;
			v.ovf = lost;
			if (!emitted && n_points > 0) begin
				cur_x = pt_x[n_points-1];
				cur_y = pt_y[n_points-1];
			end
			found = 0; best = 0; best_d = 0;
			for (i = 0; i < n_points; i++) begin
				if (!pt_live[i]) continue;
				dx = (cur_x > pt_x[i]) ? cur_x - pt_x[i] : pt_x[i] - cur_x;
				dy = (cur_y > pt_y[i]) ? cur_y - pt_y[i] : pt_y[i] - cur_y;
				d = dx * dx + dy * dy;
				if (!found || d < best_d) begin
					found  = 1;
					best   = i;
					best_d = d;
					if (best_d < gnpt_pkg::NearStop) break;
				end
			end
			if (!found) begin
				v.done = 1;
				expected_q = {expected_q, v};
				return;
			end
			cur_x = pt_x[best];
			cur_y = pt_y[best];
			pt_live[best] = 0;
			if (!emitted) begin
				v.new_path = 1;
				path_len = 0;
			end else if (best_d >= gap_sq) begin
				if (path_len < min_len) v.drop_path = 1;
				else v.new_path = 1;
				path_len = 0;
			end
			emitted = 1;
			if (path_len < gnpt_pkg::LenMax) path_len++;
			v.x = cur_x;
			v.y = cur_y;
			expected_q = {expected_q, v};
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_vertex(vertex_t got);
			vertex_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("vertex x=%0d y=%0d with no fetch pending", got.x, got.y));
				return;
			end
			want = expected_q.pop_front();
			if (got.x !== want.x)
				report($sformatf("vertex %0d x got %0d want %0d", n_checked, got.x, want.x));
			if (got.y !== want.y)
				report($sformatf("vertex %0d y got %0d want %0d", n_checked, got.y, want.y));
			if (got.new_path !== want.new_path)
				report($sformatf("vertex %0d new_path got %b want %b", n_checked,
					got.new_path, want.new_path));
			if (got.drop_path !== want.drop_path)
				report($sformatf("vertex %0d drop_path got %b want %b", n_checked,
					got.drop_path, want.drop_path));
			if (got.done !== want.done)
				report($sformatf("vertex %0d done got %b want %b", n_checked, got.done, want.done));
			if (got.ovf !== want.ovf)
				report($sformatf("vertex %0d overflow got %b want %b", n_checked,
					got.ovf, want.ovf));
			n_checked++;
			n_starts += want.new_path;
			n_drops  += want.drop_path;
			n_empty  += want.done;
			n_lost   += want.ovf;
		endtask
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [7:0]                    s_tdata = '0;
	logic [1:0]                    s_tuser = '0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [23:0]                   m_tdata;
	logic [3:0]                    m_tuser;
	logic                          cfg_we = 1'b0;
	logic [gnpt_pkg::CfgAddrW-1:0] cfg_addr = '0;
	logic [gnpt_pkg::CfgDataW-1:0] cfg_wdata = '0;

	vertex_scoreboard sb = new();
	int send_idle = 0;
	int recv_idle = 0;
	int n_sent = 0;
	int cycle_count = 0;

	greedy_nearest_point_path_tracer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tuser  (m_tuser),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	always #4 clk = ~clk;

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_vertex('{x: m_tdata[9:0], y: m_tdata[19:10], new_path: m_tuser[0],
				drop_path: m_tuser[1], done: m_tuser[2], ovf: m_tuser[3]});
	end

	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("[FAIL] regression broken");
		$finish;
	end

	// All tasks start and end on a falling edge.
	task send_request(logic mode, logic [gnpt_pkg::PixW-1:0] pixel, logic fs);
		if ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pixel;
		s_tuser  <= {fs, mode};
		do @(posedge clk); while (!s_tready);
		sb.note_request(mode, pixel, fs);
		n_sent++;
		@(negedge clk);
	endtask

	task settle(int extra);
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	task write_reg(gnpt_pkg::cfg_reg_t r, logic [gnpt_pkg::CfgDataW-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= r;
		cfg_wdata <= v;
		sb.set_reg(r, v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [gnpt_pkg::PixW-1:0] pick_pixel(int bright_pct);
		return ($urandom_range(99) < bright_pct) ? gnpt_pkg::PixW'($urandom_range(129, 255))
			: gnpt_pkg::PixW'($urandom_range(0, 128));
	endfunction

	// One frame: loads, then as many fetches as live points plus zero to two more, with stray loads mixed in.
	task random_frame(int max_pix);
		int npix, bright_pct, nfetch, k;
		npix       = $urandom_range(1, max_pix);
		bright_pct = $urandom_range(15, 80);
		for (k = 0; k < npix; k++)
			send_request(gnpt_pkg::ModeLoad, pick_pixel(bright_pct), k == 0);
		nfetch = sb.live_count() + $urandom_range(0, 2);
		for (k = 0; k < nfetch; k++) begin
			if ($urandom_range(9) == 0) settle(0);
			if ($urandom_range(11) == 0)
				send_request(gnpt_pkg::ModeLoad, pick_pixel(60), 1'b0);
			send_request(gnpt_pkg::ModeFetch, gnpt_pkg::PixW'($urandom),
				1'($urandom_range(1)));
		end
		if ($urandom_range(4) == 0) begin
			repeat ($urandom_range(1, 4))
				send_request($urandom_range(1) ? gnpt_pkg::ModeFetch : gnpt_pkg::ModeLoad,
					gnpt_pkg::PixW'($urandom), $urandom_range(3) == 0);
		end
	endtask

	task random_phase(int target, bit vary_cfg);
		int start;
		start = n_sent;
		while (n_sent - start < target) begin
			if (vary_cfg) begin
				settle(SettleCycles);
				write_reg(gnpt_pkg::REG_IMAGE_WIDTH, ($urandom_range(9) == 0) ?
					gnpt_pkg::CfgDataW'(1024) : gnpt_pkg::CfgDataW'($urandom_range(1, 12)));
				write_reg(gnpt_pkg::REG_MIN_GAP_SQ, gnpt_pkg::CfgDataW'($urandom_range(0, 20)));
				write_reg(gnpt_pkg::REG_MIN_PATH_LEN, gnpt_pkg::CfgDataW'($urandom_range(0, 5)));
			end
			random_frame(12);
		end
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle = 6;
		recv_idle = 87;
		write_reg(gnpt_pkg::REG_IMAGE_WIDTH, 13'd4);
		write_reg(gnpt_pkg::REG_MIN_PATH_LEN, 13'd3);
		// 4-wide frame, threshold pixel values on both sides of bright
		send_request(gnpt_pkg::ModeLoad, 8'd255, 1'b1);
		send_request(gnpt_pkg::ModeLoad, 8'd128, 1'b0);
		send_request(gnpt_pkg::ModeLoad, 8'd129, 1'b0);
		send_request(gnpt_pkg::ModeLoad, 8'd0, 1'b0);
		send_request(gnpt_pkg::ModeLoad, 8'd200, 1'b0);
		send_request(gnpt_pkg::ModeLoad, 8'd127, 1'b0);
		send_request(gnpt_pkg::ModeLoad, 8'd1, 1'b0);
		send_request(gnpt_pkg::ModeLoad, 8'd130, 1'b0);
		repeat (2) begin
			send_request(gnpt_pkg::ModeFetch, 8'h00, 1'b0);
			send_request(gnpt_pkg::ModeFetch, 8'hFF, 1'b0);
		end
		settle(0);
		// store drained; frame_start on a fetch has no effect
		send_request(gnpt_pkg::ModeFetch, 8'hA5, 1'b1);
		send_request(gnpt_pkg::ModeLoad, 8'd255, 1'b0);
		send_request(gnpt_pkg::ModeFetch, 8'h5A, 1'b0);
		send_request(gnpt_pkg::ModeLoad, 8'd0, 1'b1);
		send_request(gnpt_pkg::ModeFetch, 8'hFF, 1'b0);

		settle(SettleCycles);
		write_reg(gnpt_pkg::REG_IMAGE_WIDTH, 13'd5);
		write_reg(gnpt_pkg::REG_MIN_GAP_SQ, 13'd0);
		write_reg(gnpt_pkg::REG_MIN_PATH_LEN, 13'd2);
		random_phase(36, 1'b0);

		settle(SettleCycles);
		send_idle = 87;
		recv_idle = 6;
		write_reg(gnpt_pkg::REG_IMAGE_WIDTH, 13'h1FFF);
		write_reg(gnpt_pkg::REG_MIN_GAP_SQ, 13'h1FFF);
		write_reg(gnpt_pkg::REG_MIN_PATH_LEN, 13'h1FFF);
		random_phase(36, 1'b0);

		settle(SettleCycles);
		send_idle = 0;
		recv_idle = 0;
		random_phase(36, 1'b1);

		settle(SettleCycles);
		if (sb.expected_q.size() != 0)
			sb.report($sformatf("%0d vertices never arrived", sb.expected_q.size()));
		$display("covered %0d requests: %0d loads, %0d fetches, %0d vertices checked",
			n_sent, sb.n_loads, sb.n_fetches, sb.n_checked);
		$display("  %0d path starts, %0d drops, %0d empty fetches, %0d with overflow set",
			sb.n_starts, sb.n_drops, sb.n_empty, sb.n_lost);
		if (sb.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
